// ----- design/hdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hdsa_pkg
// Shared types, codes and constants for the Hamming distance admission set.
// ----------------------------------------------------------------------------
package hdsa_pkg;

  localparam int MAX_MEMBERS_DEF = 16;
  localparam int MAX_LEN_DEF     = 16;
  localparam int BASES_PER_WORD  = 16;   // 2-bit bases held in one candidate
  localparam int PAIR_THRESHOLD  = 2;    // pairs count when distance exceeds this

  // opcodes
  localparam logic [1:0] OP_ADMIT = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;

  // status codes
  localparam logic [2:0] ST_ADMITTED  = 3'd0;
  localparam logic [2:0] ST_TOO_CLOSE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [1:0] REG_OLIGO_LENGTH = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] candidate;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] nearest_distance;
    logic [4:0] member_count;
    logic [6:0] pair_score;
  } out_word_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_LOAD_LAST,
    SQ_SCAN,
    SQ_FINISH
  } seq_state_t;

endpackage

// ----- design/hdsa_store.sv -----
// ----------------------------------------------------------------------------
// hdsa_store
// Member memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hdsa_store #(
  parameter int DEPTH = hdsa_pkg::MAX_MEMBERS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/hdsa_dist.sv -----
// ----------------------------------------------------------------------------
// hdsa_dist
// Shared distance unit: counts differing bases over the first len bases.
// ----------------------------------------------------------------------------
module hdsa_dist (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [4:0]  len,
  output logic [4:0]  diff_count
);

  always_comb begin
    diff_count = '0;
    for (int i = 0; i < hdsa_pkg::BASES_PER_WORD; i++) begin
      if ((5'(i) < len) && (a[2*i +: 2] != b[2*i +: 2])) begin
        diff_count = diff_count + 5'd1;
      end
    end
  end

endmodule

// ----- design/hamming_distance_set_admission.sv -----
// ----------------------------------------------------------------------------
// hamming_distance_set_admission
// Admission set of nucleotide strings kept at a minimum Hamming distance.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the word is taken on a
//   rising edge with start high and busy low. busy stays high until the
//   result has been produced.
//   Result channel: result is valid for one cycle while done is high; the
//   receiver must take it then, it cannot stall the block.
//   Config port: cfg_we/cfg_index/cfg_data write min_distance (index 0) or
//   oligo_length (index 1); other indexes are ignored. Write
//   only while idle.
// Sequence: admit scans every member, then finishes; pop loads the newest
//   member as reference, then scans the rest. Clear, pop on empty and
//   unknown opcodes go straight to finish; done rises in the cycle after
//   finish. One member is read from the store per cycle through the shared
//   distance unit; that read port sets the rate.
// Reset: rst (sync, active high) empties the set, zeroes the pair score and
//   loads min_distance 2, oligo_length 3. The store itself is not cleared.
// ----------------------------------------------------------------------------
module hamming_distance_set_admission #(
  parameter int MAX_MEMBERS = hdsa_pkg::MAX_MEMBERS_DEF,
  parameter int MAX_LEN     = hdsa_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hdsa_pkg::in_word_t  cmd,
  output logic                done,
  output hdsa_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam int AW      = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CW      = $clog2(MAX_MEMBERS + 1);
  localparam int MAX_PAIRS = MAX_MEMBERS * (MAX_MEMBERS - 1) / 2;
  localparam int SW      = $clog2(MAX_PAIRS + 1);
  // bases compared can never exceed the word or MAX_LEN
  localparam int LEN_CAP = (MAX_LEN < hdsa_pkg::BASES_PER_WORD) ?
                           MAX_LEN : hdsa_pkg::BASES_PER_WORD;

  hdsa_pkg::seq_state_t state, state_next;

  // control state
  logic [CW-1:0] stored_count, count_next;
  logic [SW-1:0] score_count, score_next;
  logic [4:0]    min_distance;
  logic [4:0]    oligo_length;
  logic [CW-1:0] idx;
  logic          rd_pend;

  // per-item working registers
  logic [1:0]    op;
  logic [31:0]   ref_word;
  logic [4:0]    len_q;
  logic [4:0]    nearest;
  logic [CW-1:0] tally;
  logic [CW-1:0] limit;

  logic          accept;
  logic [4:0]    len_eff;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic [4:0]    diff_count;
  hdsa_pkg::out_word_t res;

  assign busy    = (state != hdsa_pkg::SQ_IDLE);
  assign accept  = start && !busy;
  assign len_eff = (32'(oligo_length) > LEN_CAP) ? 5'(LEN_CAP) : oligo_length;

  hdsa_store #(
    .DEPTH (MAX_MEMBERS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (stored_count[AW-1:0]),
    .wdata (ref_word),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // one member against the reference word per cycle
  hdsa_dist u_dist (
    .a          (mem_rdata),
    .b          (ref_word),
    .len        (len_q),
    .diff_count (diff_count)
  );

  // sequencer: next state and store read strobe
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state)
      hdsa_pkg::SQ_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            hdsa_pkg::OP_ADMIT: state_next = hdsa_pkg::SQ_SCAN;
            hdsa_pkg::OP_POP: begin
              if (stored_count == '0) begin
                state_next = hdsa_pkg::SQ_FINISH;
              end else begin
                // fetch the newest member as reference for the scan
                mem_re     = 1'b1;
                mem_raddr  = AW'(stored_count - CW'(1));
                state_next = hdsa_pkg::SQ_LOAD_LAST;
              end
            end
            default: state_next = hdsa_pkg::SQ_FINISH;
          endcase
        end
      end
      hdsa_pkg::SQ_LOAD_LAST: state_next = hdsa_pkg::SQ_SCAN;
      hdsa_pkg::SQ_SCAN: begin
        if (idx < limit) begin
          mem_re    = 1'b1;
          mem_raddr = idx[AW-1:0];
        end else begin
          // last pending read is folded in on this cycle
          state_next = hdsa_pkg::SQ_FINISH;
        end
      end
      hdsa_pkg::SQ_FINISH: state_next = hdsa_pkg::SQ_IDLE;
    endcase
  end

  // write-back decision and result word
  always_comb begin
    count_next = stored_count;
    score_next = score_count;
    mem_we     = 1'b0;
    res.status = hdsa_pkg::ST_REJECTED;
    res.nearest_distance = '0;
    case (op)
      hdsa_pkg::OP_ADMIT: begin
        res.nearest_distance = nearest;
        if (nearest < min_distance) begin
          res.status = hdsa_pkg::ST_TOO_CLOSE;
        end else if (32'(stored_count) >= MAX_MEMBERS) begin
          res.status = hdsa_pkg::ST_FULL;
        end else begin
          res.status = hdsa_pkg::ST_ADMITTED;
          mem_we     = (state == hdsa_pkg::SQ_FINISH);
          count_next = stored_count + CW'(1);
          score_next = score_count + SW'(tally);
        end
      end
      hdsa_pkg::OP_CLEAR: begin
        res.status = hdsa_pkg::ST_REMOVED;
        count_next = '0;
        score_next = '0;
      end
      hdsa_pkg::OP_POP: begin
        if (stored_count != '0) begin
          res.status = hdsa_pkg::ST_REMOVED;
          count_next = stored_count - CW'(1);
          score_next = (score_count >= SW'(tally)) ? score_count - SW'(tally) : '0;
        end
      end
      default: res.status = hdsa_pkg::ST_REJECTED;
    endcase
    res.member_count = (32'(count_next) > 31) ? 5'd31 : 5'(count_next);
    res.pair_score   = (32'(score_next) > 127) ? 7'd127 : 7'(score_next);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hdsa_pkg::SQ_IDLE;
      stored_count <= '0;
      score_count  <= '0;
      min_distance <= 5'd2;
      oligo_length <= 5'd3;
      idx          <= '0;
      rd_pend      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == hdsa_pkg::SQ_FINISH);
      if (cfg_we) begin
        if (cfg_index == hdsa_pkg::REG_MIN_DISTANCE) begin
          min_distance <= cfg_data;
        end else if (cfg_index == hdsa_pkg::REG_OLIGO_LENGTH) begin
          oligo_length <= cfg_data;
        end
      end
      if (state == hdsa_pkg::SQ_IDLE) begin
        idx     <= '0;
        rd_pend <= 1'b0;
      end else if (state == hdsa_pkg::SQ_SCAN) begin
        rd_pend <= mem_re;
        if (mem_re) begin
          idx <= idx + CW'(1);
        end
      end
      if (state == hdsa_pkg::SQ_FINISH) begin
        stored_count <= count_next;
        score_count  <= score_next;
      end
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    if (state == hdsa_pkg::SQ_IDLE && accept) begin
      op       <= cmd.opcode;
      ref_word <= cmd.candidate;
      len_q    <= len_eff;
      nearest  <= len_eff;
      tally    <= '0;
      limit    <= (cmd.opcode == hdsa_pkg::OP_POP) ? stored_count - CW'(1) : stored_count;
    end
    if (state == hdsa_pkg::SQ_LOAD_LAST) begin
      ref_word <= mem_rdata;
    end
    if (state == hdsa_pkg::SQ_SCAN && rd_pend) begin
      if (diff_count < nearest) begin
        nearest <= diff_count;
      end
      if (32'(diff_count) > hdsa_pkg::PAIR_THRESHOLD) begin
        tally <= tally + CW'(1);
      end
    end
    if (state == hdsa_pkg::SQ_FINISH) begin
      result <= res;
    end
  end

endmodule

// ----- tb/sv/hamming_distance_set_admission_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamming_distance_set_admission_tb
// Self-checking bench for the admission set: a directed script of command
// words and register writes, then random phases under varying settings. Every
// result word is checked field by field against a typed value or a copy of the set.
// ----------------------------------------------------------------------------
module hamming_distance_set_admission_tb;

  localparam logic [1:0] OP_ILLEGAL  = 2'd3;   // unused opcode, must be rejected
  localparam logic [1:0] REG_SPARE_A = 2'd2;   // indexes past the register list
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int N_SLOTS      = hdsa_pkg::MAX_MEMBERS_DEF;
  localparam int RANDOM_WORDS = 550;
  localparam int CYCLE_LIMIT  = 200000;        // watchdog limit on the whole run
  localparam int DRAIN_TAIL   = 40;            // idle tail after the final drain
  localparam int REPORT_MAX   = 10;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic                busy;
  hdsa_pkg::in_word_t  cmd       = '0;
  logic                done;
  hdsa_pkg::out_word_t result;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [4:0]          cfg_data  = '0;

  always #2 clk = ~clk;

  hamming_distance_set_admission dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the set, its score and its two registers (reset view)
  // --------------------------------------------------------------------------
  logic [31:0] held_strings [N_SLOTS];
  logic [4:0]  held_count   = '0;
  logic [6:0]  pair_total   = '0;
  logic [4:0]  min_dist_reg = 5'd2;
  logic [4:0]  length_reg   = 5'd3;

  hdsa_pkg::out_word_t expected_outcomes [$];
  int        mismatches   = 0;
  int        cycle_count  = 0;
  int        random_words = 0;

  // bases actually compared: register saturates at MAX_LEN and at the word size
  function automatic int span();
    int n;
    n = int'(length_reg);
    if (n > hdsa_pkg::MAX_LEN_DEF)    n = hdsa_pkg::MAX_LEN_DEF;
    if (n > hdsa_pkg::BASES_PER_WORD) n = hdsa_pkg::BASES_PER_WORD;
    return n;
  endfunction

  function automatic logic [4:0] base_mismatches(logic [31:0] a, logic [31:0] b, int n);
    logic [4:0] d;
    d = '0;
    for (int i = 0; i < hdsa_pkg::BASES_PER_WORD; i++)
      if (i < n && a[2*i +: 2] != b[2*i +: 2]) d++;
    return d;
  endfunction

  // Applies one command word to the copy and returns the result word it gives.
  function automatic hdsa_pkg::out_word_t admission_outcome(hdsa_pkg::in_word_t w);
    int                  n;
    logic [4:0]          nearest;
    logic [4:0]          d;
    logic [4:0]          last;
    logic [6:0]          gained;
    logic [6:0]          lost;
    hdsa_pkg::out_word_t r;
    n = span();
    r = '0;
    case (w.opcode)
      hdsa_pkg::OP_ADMIT: begin
        nearest = n[4:0];
        gained  = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (i < held_count) begin
            d = base_mismatches(held_strings[i], w.candidate, n);
            if (d < nearest) nearest = d;
            if (d > hdsa_pkg::PAIR_THRESHOLD) gained++;
          end
        end
        // closeness is judged before room
        if (nearest < min_dist_reg) begin
          r.status = hdsa_pkg::ST_TOO_CLOSE;
        end else if (held_count >= N_SLOTS) begin
          r.status = hdsa_pkg::ST_FULL;
        end else begin
          held_strings[held_count] = w.candidate;
          held_count++;
          pair_total += gained;
          r.status = hdsa_pkg::ST_ADMITTED;
        end
        r.nearest_distance = nearest;
      end
      hdsa_pkg::OP_CLEAR: begin
        held_count = '0;
        pair_total = '0;
        r.status   = hdsa_pkg::ST_REMOVED;
      end
      hdsa_pkg::OP_POP: begin
        if (held_count == 0) begin
          r.status = hdsa_pkg::ST_REJECTED;
        end else begin
          last = held_count - 5'd1;
          lost = '0;
          for (int i = 0; i < N_SLOTS; i++) begin
            if (i < last) begin
              if (base_mismatches(held_strings[i], held_strings[last], n) >
                  hdsa_pkg::PAIR_THRESHOLD)
                lost++;
            end
          end
          pair_total = (pair_total >= lost) ? pair_total - lost : '0;
          held_count = last;
          r.status   = hdsa_pkg::ST_REMOVED;
        end
      end
      default: begin
        r.status = hdsa_pkg::ST_REJECTED;
      end
    endcase
    r.member_count = held_count;
    r.pair_score   = pair_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: one result word per done cycle, oldest expectation first
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, hdsa_pkg::out_word_t want,
                                 hdsa_pkg::out_word_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected st=%0d nd=%0d mc=%0d ps=%0d, got st=%0d nd=%0d mc=%0d ps=%0d",
               $time, what, want.status, want.nearest_distance, want.member_count,
               want.pair_score, got.status, got.nearest_distance, got.member_count,
               got.pair_score);
  endtask

  hdsa_pkg::out_word_t oldest;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result word with nothing pending", '0, result);
      end else begin
        oldest = expected_outcomes.pop_front();
        if (result.status !== oldest.status ||
            result.nearest_distance !== oldest.nearest_distance ||
            result.member_count !== oldest.member_count ||
            result.pair_score !== oldest.pair_score)
          report_mismatch("result word differs", oldest, result);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Presents a word and holds start until the edge that takes it (busy low).
  // A typed expectation replaces the predicted one but the copy still moves on.
  task automatic issue(hdsa_pkg::in_word_t w, bit typed, hdsa_pkg::out_word_t want);
    hdsa_pkg::out_word_t predicted;
    cmd   <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = admission_outcome(w);
    expected_outcomes.insert(expected_outcomes.size(), typed ? want : predicted);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_length(bit quiet);
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 5) return 0;
    if (r < 9)          return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Stop sending and wait until every result word is in and the block is idle.
  // Checked on the falling edge so the queue is never read mid-update.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (expected_outcomes.size() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hdsa_pkg::REG_MIN_DISTANCE: min_dist_reg = val;
      hdsa_pkg::REG_OLIGO_LENGTH: length_reg   = val;
      default: ;  // spare index, no effect
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Directed script
  // --------------------------------------------------------------------------
  typedef struct {
    bit                  is_reg;
    hdsa_pkg::in_word_t  w;
    int                  reps;
    bit                  typed;
    hdsa_pkg::out_word_t want;
    logic [1:0]          idx;
    logic [4:0]          val;
  } script_row_t;

  script_row_t script [$];

  function automatic hdsa_pkg::out_word_t outcome(logic [2:0] st, logic [4:0] nd,
                                                  logic [4:0] mc, logic [6:0] ps);
    return {st, nd, mc, ps};
  endfunction

  function automatic void add_word(logic [1:0] op, logic [31:0] c, int reps, bit typed,
                                   hdsa_pkg::out_word_t want);
    script_row_t row;
    row = '{is_reg: 1'b0, w: '0, reps: reps, typed: typed, want: want, idx: '0, val: '0};
    row.w.opcode    = op;
    row.w.candidate = c;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [4:0] val);
    script_row_t row;
    row = '{is_reg: 1'b1, w: '0, reps: 0, typed: 1'b0, want: '0, idx: idx, val: val};
    script.insert(script.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------
  // Random strings, near copies of members (a few bases flipped inside the
  // compared span) to provoke rejections, and the all-A / all-T extremes.
  function automatic logic [31:0] pick_candidate();
    logic [31:0] c;
    logic [1:0]  flip;
    int          b;
    int          n;
    c = $urandom;
    n = span();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        if (held_count != 0) begin
          c = held_strings[$urandom_range(0, held_count - 1)];
          repeat ($urandom_range(0, 3)) begin
            b    = $urandom_range(0, (n == 0) ? 0 : n - 1);
            flip = 2'($urandom_range(1, 3));
            c[2*b +: 2] = c[2*b +: 2] ^ flip;
          end
        end
      end
      7: c = '0;
      8: c = '1;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return hdsa_pkg::OP_ADMIT;
    if (r < 90) return hdsa_pkg::OP_POP;
    if (r < 95) return hdsa_pkg::OP_CLEAR;
    return OP_ILLEGAL;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    hdsa_pkg::in_word_t w;
    logic [4:0]         len;
    logic [4:0]         dmin;
    int                 eff;
    int                 phase_len;
    bit                 quiet;

    // reset settings: min_distance 2, oligo_length 3
    add_word(hdsa_pkg::OP_POP,   32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_REJECTED,  5'd0, 5'd0, 7'd0));
    add_word(hdsa_pkg::OP_ADMIT, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_ADMITTED,  5'd3, 5'd1, 7'd0));
    add_word(hdsa_pkg::OP_ADMIT, 32'hFFFF_FFFF, 1, 1'b1,
             outcome(hdsa_pkg::ST_ADMITTED,  5'd3, 5'd2, 7'd1));
    // bases beyond the length are ignored: this one matches all-A exactly
    add_word(hdsa_pkg::OP_ADMIT, 32'hFFFF_FFC0, 1, 1'b1,
             outcome(hdsa_pkg::ST_TOO_CLOSE, 5'd0, 5'd2, 7'd1));
    add_word(OP_ILLEGAL,         32'hA5A5_A5A5, 1, 1'b1,
             outcome(hdsa_pkg::ST_REJECTED,  5'd0, 5'd2, 7'd1));
    add_word(hdsa_pkg::OP_POP,   32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_REMOVED,   5'd0, 5'd1, 7'd0));
    add_word(hdsa_pkg::OP_CLEAR, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_REMOVED,   5'd0, 5'd0, 7'd0));
    // zero length: every distance is zero, min 0 lets the set fill up
    add_reg(hdsa_pkg::REG_MIN_DISTANCE, 5'd0);
    add_reg(hdsa_pkg::REG_OLIGO_LENGTH, 5'd0);
    add_word(hdsa_pkg::OP_ADMIT, 32'h1234_5678, N_SLOTS, 1'b0, '0);
    add_word(hdsa_pkg::OP_ADMIT, 32'hDEAD_BEEF, 1, 1'b1,
             outcome(hdsa_pkg::ST_FULL,      5'd0, 5'd16, 7'd0));
    // full and too close at once: too close wins
    add_reg(hdsa_pkg::REG_MIN_DISTANCE, 5'd1);
    add_word(hdsa_pkg::OP_ADMIT, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_TOO_CLOSE, 5'd0, 5'd16, 7'd0));
    add_word(hdsa_pkg::OP_POP,   32'h0,         1, 1'b0, '0);
    add_word(hdsa_pkg::OP_CLEAR, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_REMOVED,   5'd0, 5'd0, 7'd0));
    // empty set reports the length as nearest, which can still be too close
    add_reg(hdsa_pkg::REG_MIN_DISTANCE, 5'd16);
    add_word(hdsa_pkg::OP_ADMIT, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_TOO_CLOSE, 5'd0, 5'd0, 7'd0));
    add_reg(hdsa_pkg::REG_OLIGO_LENGTH, 5'd3);
    add_word(hdsa_pkg::OP_ADMIT, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_TOO_CLOSE, 5'd3, 5'd0, 7'd0));
    // length register past the word size saturates at 16 bases
    add_reg(hdsa_pkg::REG_OLIGO_LENGTH, 5'd31);
    add_word(hdsa_pkg::OP_ADMIT, 32'h0,         1, 1'b1,
             outcome(hdsa_pkg::ST_ADMITTED,  5'd16, 5'd1, 7'd0));
    add_word(hdsa_pkg::OP_ADMIT, 32'hFFFF_FFFF, 1, 1'b1,
             outcome(hdsa_pkg::ST_ADMITTED,  5'd16, 5'd2, 7'd1));
    add_reg(hdsa_pkg::REG_MIN_DISTANCE, 5'd31);
    add_word(hdsa_pkg::OP_ADMIT, 32'hAAAA_AAAA, 1, 1'b1,
             outcome(hdsa_pkg::ST_TOO_CLOSE, 5'd16, 5'd2, 7'd1));
    // spare indexes must leave both registers alone
    add_reg(REG_SPARE_A, 5'd31);
    add_reg(REG_SPARE_B, 5'd0);
    add_word(hdsa_pkg::OP_POP,   32'h0,         1, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        write_reg(script[i].idx, script[i].val);
      end else begin
        repeat (script[i].reps) begin
          issue(script[i].w, script[i].typed, script[i].want);
          pause(gap_length(1'b0));
        end
      end
    end

    // Random phases: new settings each time, set carried over between phases.
    while (random_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       len = 5'd0;
        1:       len = 5'($urandom_range(17, 31));
        2:       len = 5'd16;
        default: len = 5'($urandom_range(1, 12));
      endcase
      eff = (len > 16) ? 16 : int'(len);
      case ($urandom_range(0, 9))
        0:       dmin = 5'd0;
        1:       dmin = 5'($urandom_range(17, 31));
        2:       dmin = 5'd16;
        default: dmin = 5'($urandom_range(1, eff / 2 + 1));
      endcase
      write_reg(hdsa_pkg::REG_OLIGO_LENGTH, len);
      write_reg(hdsa_pkg::REG_MIN_DISTANCE, dmin);
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  5'($urandom_range(0, 31)));

      quiet     = ($urandom_range(0, 3) == 0);   // some phases run back to back
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        w.opcode    = pick_opcode();
        w.candidate = pick_candidate();
        issue(w, 1'b0, '0);
        random_words++;
        // occasionally hold off until the block has emptied out
        if (!quiet && $urandom_range(0, 29) == 0)
          drain();
        else
          pause(gap_length(quiet));
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
design/hdsa_pkg.sv
design/hdsa_store.sv
design/hdsa_dist.sv
design/hamming_distance_set_admission.sv
tb/sv/hamming_distance_set_admission_tb.sv
